// File: hw/rtl/atd_pkg.sv
// Shared types and constants for the aggregate tag deframer.
// No dependencies; imported by atd_apb_regs and aggregate_tag_deframer.
package atd_pkg;

    // Tag layout
    localparam int HDR_BYTES     = 11;
    localparam int TRL_BYTES     = 4;
    localparam int MIN_TAG_BYTES = HDR_BYTES + TRL_BYTES;

    // Register map (index taken from paddr[2])
    localparam logic REG_AUDIO = 1'b0;
    localparam logic REG_VIDEO = 1'b1;

    localparam logic [7:0] AUDIO_CODE_RST = 8'd8;
    localparam logic [7:0] VIDEO_CODE_RST = 8'd9;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TRUNC    = 2'd1,
        ERR_PAST_END = 2'd2,
        ERR_TRAILER  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] audio_code;
        logic [7:0] video_code;
    } t_cfg;

endpackage

// File: hw/rtl/aggregate_tag_deframer.sv
// Aggregate tag deframer top level: byte walker over packed media tags.
// Depends on atd_pkg and atd_apb_regs.
//
//  channel   dir  handshake                 carries
//  s_axis    in   tvalid/tready             one message byte + length, base time, last flag
//  m_axis    out  tvalid/tready             one tag descriptor or error report
//  apb       in   psel/penable (pready=1)   audio / video type code registers
//
// One byte per cycle sustained. Each beat is first held in the input register, then
// the walker updates its state from it and loads the result register. A full
// result register that is not taken stalls the walker, and the input register then
// holds its beat.
// Reset (synchronous, active low) clears the walker state and restores codes 8 / 9.
module aggregate_tag_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_byte[7:0], message_length[31:8],
                                        // base_timestamp[63:32]
    input  logic        s_axis_tlast,   // final_byte
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // media_timestamp[31:0], payload_offset[55:32],
                                        // payload_length[79:56]
    output logic [2:0]  m_axis_tuser,   // error_code[1:0], is_video[2]
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import atd_pkg::*;

    t_cfg w_cfg;

    atd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic [23:0] r_in_len;
    logic [31:0] r_in_base;
    logic        r_in_last;
    logic        w_adv;

    // walker advances when the result slot is free or being drained
    assign w_adv         = r_in_vld && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_len  <= s_axis_tdata[31:8];
            r_in_base <= s_axis_tdata[63:32];
            r_in_last <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Walker state
    // ------------------------------------------------------------------
    logic [23:0] r_pos, n_pos;            // offset of next byte
    logic [23:0] r_tag_start, n_tag_start;
    logic [23:0] r_rel, n_rel;            // offset inside current tag (pos - tag_start)
    logic [7:0]  r_kind, n_kind;
    logic [23:0] r_size, n_size;
    logic [31:0] r_time, n_time;
    logic [31:0] r_first_time, n_first_time;
    logic        r_first_seen, n_first_seen;
    logic [31:0] r_trail, n_trail;
    logic        r_failed, n_failed;

    // Values derived from header fields, refreshed every clock. The header fields
    // they use are written on earlier beats, never the beat just before the one that
    // reads them, so the register lag never shows.
    logic [25:0] r_tag_lim;    // tag_start + 15 + size
    logic [24:0] r_pay_end;    // size + 11: first trailer offset, also expected trailer
    logic [24:0] r_tag_last;   // size + 14: last trailer offset
    logic [31:0] r_tdelta;     // tag time minus first tag time, 0 before first tag

    always_ff @(posedge i_clk) begin
        r_tag_lim  <= {2'b0, r_tag_start} + 26'(MIN_TAG_BYTES) + {2'b0, r_size};
        r_pay_end  <= {1'b0, r_size} + 25'(HDR_BYTES);
        r_tag_last <= {1'b0, r_size} + 25'(MIN_TAG_BYTES - 1);
        r_tdelta   <= r_first_seen ? (r_time - r_first_time) : 32'h0;
    end

    // result of this beat
    logic        w_emit;
    t_err        w_err;
    logic        w_vid;
    logic [31:0] w_ts;
    logic [23:0] w_off;
    logic [23:0] w_len;
    logic        w_is_audio;
    logic        w_is_vid;

    assign w_is_audio = (r_kind == w_cfg.audio_code);
    assign w_is_vid   = !w_is_audio && (r_kind == w_cfg.video_code);

    always_comb begin
        n_pos        = r_pos;
        n_tag_start  = r_tag_start;
        n_rel        = r_rel;
        n_kind       = r_kind;
        n_size       = r_size;
        n_time       = r_time;
        n_first_time = r_first_time;
        n_first_seen = r_first_seen;
        n_trail      = r_trail;
        n_failed     = r_failed;
        w_emit       = 1'b0;
        w_err        = ERR_NONE;
        w_vid        = 1'b0;
        w_ts         = 32'h0;
        w_off        = 24'h0;
        w_len        = 24'h0;

        if (!r_failed && (r_pos < r_in_len)) begin
            n_rel = r_rel + 24'd1;
            if (r_rel == 24'd0) begin
                if ((r_in_len - r_pos) < 24'(MIN_TAG_BYTES)) begin
                    n_failed = 1'b1;
                    w_emit   = 1'b1;
                    w_err    = ERR_TRUNC;
                end else begin
                    n_kind  = r_in_byte;
                    n_size  = 24'h0;
                    n_time  = 32'h0;
                    n_trail = 32'h0;
                end
            end else if (r_rel < 24'(HDR_BYTES)) begin
                // big-endian size, then time low 24 bits, then time high byte
                unique case (r_rel[3:0])
                    4'd1:    n_size = {r_in_byte, 16'h0};
                    4'd2:    n_size[15:8] = r_in_byte;
                    4'd3:    n_size[7:0] = r_in_byte;
                    4'd4:    n_time = {8'h0, r_in_byte, 16'h0};
                    4'd5:    n_time[15:8] = r_in_byte;
                    4'd6:    n_time[7:0] = r_in_byte;
                    4'd7:    n_time[31:24] = r_in_byte;
                    default: n_time = r_time;
                endcase
                if ((r_rel == 24'(HDR_BYTES - 1)) && (r_tag_lim > {2'b0, r_in_len})) begin
                    n_failed = 1'b1;
                    w_emit   = 1'b1;
                    w_err    = ERR_PAST_END;
                end
            end else if ({1'b0, r_rel} >= r_pay_end) begin
                n_trail = {r_trail[23:0], r_in_byte};
                if ({1'b0, r_rel} == r_tag_last) begin
                    if (n_trail != {7'h0, r_pay_end}) begin
                        n_failed = 1'b1;
                        w_emit   = 1'b1;
                        w_err    = ERR_TRAILER;
                    end else begin
                        if (!r_first_seen) begin
                            n_first_time = r_time;
                            n_first_seen = 1'b1;
                        end
                        if (w_is_audio || w_is_vid) begin
                            w_emit = 1'b1;
                            w_vid  = w_is_vid;
                            w_ts   = r_in_base + r_tdelta;
                            w_off  = r_tag_start + 24'(HDR_BYTES);
                            w_len  = r_size;
                        end
                        n_tag_start = r_pos + 24'd1;
                        n_rel       = 24'd0;
                    end
                end
            end
            n_pos = r_pos + 24'd1;
        end

        // message end: report a tag cut short, then drop all message state
        if (r_in_last) begin
            if (!w_emit && !n_failed && (n_rel != 24'd0)) begin
                w_emit = 1'b1;
                w_err  = ERR_TRUNC;
            end
            n_pos        = 24'h0;
            n_tag_start  = 24'h0;
            n_rel        = 24'h0;
            n_kind       = 8'h0;
            n_size       = 24'h0;
            n_time       = 32'h0;
            n_first_time = 32'h0;
            n_first_seen = 1'b0;
            n_trail      = 32'h0;
            n_failed     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 24'h0;
            r_tag_start  <= 24'h0;
            r_rel        <= 24'h0;
            r_kind       <= 8'h0;
            r_size       <= 24'h0;
            r_time       <= 32'h0;
            r_first_time <= 32'h0;
            r_first_seen <= 1'b0;
            r_trail      <= 32'h0;
            r_failed     <= 1'b0;
        end else if (w_adv) begin
            r_pos        <= n_pos;
            r_tag_start  <= n_tag_start;
            r_rel        <= n_rel;
            r_kind       <= n_kind;
            r_size       <= n_size;
            r_time       <= n_time;
            r_first_time <= n_first_time;
            r_first_seen <= n_first_seen;
            r_trail      <= n_trail;
            r_failed     <= n_failed;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        r_out_vld;
    t_err        r_out_err;
    logic        r_out_vid;
    logic [31:0] r_out_ts;
    logic [23:0] r_out_off;
    logic [23:0] r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_err <= w_err;
            r_out_vid <= w_vid;
            r_out_ts  <= w_ts;
            r_out_off <= w_off;
            r_out_len <= w_len;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_len, r_out_off, r_out_ts};
    assign m_axis_tuser  = {r_out_vid, r_out_err};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rel_tracks_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel == (r_pos - r_tag_start))
        else $error("tag offset out of step with byte position");

    a_start_le_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_start <= r_pos)
        else $error("tag start beyond byte position");

    a_quiet_after_fail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && w_adv) |-> !w_emit)
        else $error("result after message failure");

    a_fail_latched : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && (w_err != ERR_NONE) && !r_in_last) |=> r_failed)
        else $error("error reported without failing the message");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> ($stable(r_out_ts) && $stable(r_out_err)))
        else $error("pending result overwritten");

endmodule

// File: hw/rtl/atd_apb_regs.sv
// APB register file for the tag deframer: audio and video type codes.
// Depends on atd_pkg.
module atd_apb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output atd_pkg::t_cfg      o_cfg
);
    import atd_pkg::*;

    logic [7:0] r_audio_code;
    logic [7:0] r_video_code;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_audio_code <= AUDIO_CODE_RST;
            r_video_code <= VIDEO_CODE_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_VIDEO) begin
                r_video_code <= pwdata[7:0];
            end else begin
                r_audio_code <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_VIDEO) begin
            prdata = {24'h0, r_video_code};
        end else begin
            prdata = {24'h0, r_audio_code};
        end
    end

    assign o_cfg.audio_code = r_audio_code;
    assign o_cfg.video_code = r_video_code;

endmodule
